>>> rtl/dbec_pkg.sv
package dbec_pkg;

    // Default width of a block index.
    localparam int BLOCK_INDEX_BITS_DEF = 48;

    // Depth of the queue between the classifier and the extent formatter.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_RUN_BLOCKS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_RUN_BLOCKS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_SHIFT    = 2'd2;

    localparam logic [15:0] MIN_RUN_BLOCKS_RESET = 16'd256;
    localparam logic [15:0] MAX_RUN_BLOCKS_RESET = 16'd2048;
    localparam logic [4:0]  BLOCK_SHIFT_RESET    = 5'd12;

    localparam int OFFSET_BITS = 64;
    localparam int BYTES_BITS  = 32;

    // Control part of one pending result.
    typedef struct packed {
        logic present;
        logic ext_valid;
        logic list_end;
    } res_ctl_t;

endpackage

>>> rtl/dbec_front.sv
module dbec_front #(
    parameter int IDX_BITS = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   block_dirty,
    input  logic                   final_block,
    input  logic [15:0]            min_run_blocks,
    input  logic [15:0]            max_run_blocks,
    output dbec_pkg::res_ctl_t     ctl0,
    output logic [IDX_BITS-1:0]    start0,
    output logic [IDX_BITS:0]      count0,
    output dbec_pkg::res_ctl_t     ctl1,
    output logic [IDX_BITS-1:0]    start1,
    output logic [IDX_BITS:0]      count1
);
    import dbec_pkg::*;

    logic [IDX_BITS-1:0] pos_reg;
    logic                open_reg;
    logic [IDX_BITS-1:0] start_reg;
    // Distance from the run start to the last dirty block.
    logic [IDX_BITS-1:0] span_reg;
    // Distance from the run start to the block now arriving.
    logic [IDX_BITS-1:0] dist_reg;

    logic                open_next;
    logic [IDX_BITS-1:0] start_next;
    logic [IDX_BITS-1:0] span_next;
    logic [IDX_BITS-1:0] dist_next;
    logic                cut_run;
    logic                close_run;

    always_comb begin
        cut_run   = block_dirty && open_reg && (dist_reg == IDX_BITS'(max_run_blocks));
        close_run = !block_dirty && open_reg && (dist_reg >= IDX_BITS'(min_run_blocks));

        open_next  = open_reg;
        start_next = start_reg;
        span_next  = span_reg;
        dist_next  = dist_reg + IDX_BITS'(1);

        ctl0   = '0;
        start0 = start_reg;
        count0 = {1'b0, dist_reg};

        if (block_dirty) begin
            if (!open_reg || cut_run) begin
                open_next  = 1'b1;
                start_next = pos_reg;
                span_next  = '0;
                dist_next  = IDX_BITS'(1);
            end else begin
                span_next = dist_reg;
            end
            if (cut_run) begin
                ctl0.present   = 1'b1;
                ctl0.ext_valid = 1'b1;
            end
        end else if (close_run) begin
            ctl0.present   = 1'b1;
            ctl0.ext_valid = 1'b1;
            ctl0.list_end  = final_block;
            count0         = {1'b0, span_reg} + (IDX_BITS + 1)'(1);
            open_next      = 1'b0;
        end

        // The final block flushes what is still open, or leaves an end marker.
        ctl1   = '0;
        start1 = start_next;
        count1 = {1'b0, span_next} + (IDX_BITS + 1)'(1);
        if (final_block) begin
            if (open_next) begin
                ctl1.present   = 1'b1;
                ctl1.ext_valid = 1'b1;
                ctl1.list_end  = 1'b1;
            end else if (!ctl0.present) begin
                ctl1.present  = 1'b1;
                ctl1.list_end = 1'b1;
                start1        = '0;
                count1        = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            open_reg  <= 1'b0;
            start_reg <= '0;
            span_reg  <= '0;
            dist_reg  <= '0;
        end else if (accept) begin
            pos_reg   <= final_block ? '0 : pos_reg + IDX_BITS'(1);
            open_reg  <= final_block ? 1'b0 : open_next;
            start_reg <= start_next;
            span_reg  <= span_next;
            dist_reg  <= dist_next;
        end
    end

endmodule

>>> rtl/dbec_queue.sv
module dbec_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    slots [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] fill_reg;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        ptr_inc = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
    endfunction

    assign head  = slots[rd_ptr_reg];
    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == CNT_BITS'(DEPTH));

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + CNT_BITS'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - CNT_BITS'(1);
            end
        end
    end

endmodule

>>> rtl/dbec_back.sv
module dbec_back #(
    parameter int IDX_BITS = 48
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    output logic                           q_pop,
    input  dbec_pkg::res_ctl_t             ctl0,
    input  logic [IDX_BITS-1:0]            start0,
    input  logic [IDX_BITS:0]              count0,
    input  dbec_pkg::res_ctl_t             ctl1,
    input  logic [IDX_BITS-1:0]            start1,
    input  logic [IDX_BITS:0]              count1,
    input  logic [4:0]                     block_shift,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_extent_valid,
    output logic [dbec_pkg::OFFSET_BITS-1:0] m_extent_offset,
    output logic [dbec_pkg::BYTES_BITS-1:0]  m_extent_bytes,
    output logic                           m_list_end
);
    import dbec_pkg::*;

    logic                    phase_reg;
    logic                    phase_next;
    logic                    valid_reg;
    logic                    ext_valid_reg;
    logic [OFFSET_BITS-1:0]  offset_reg;
    logic [BYTES_BITS-1:0]   bytes_reg;
    logic                    end_reg;

    logic                    load;
    logic                    use_slot0;
    res_ctl_t                sel_ctl;
    logic [IDX_BITS-1:0]     sel_start;
    logic [IDX_BITS:0]       sel_count;
    logic [5:0]              sat_shift;
    logic                    saturate;
    logic [OFFSET_BITS-1:0]  offset_calc;
    logic [OFFSET_BITS-1:0]  bytes_wide;
    logic [BYTES_BITS-1:0]   bytes_calc;

    always_comb begin
        load      = !q_empty && (!valid_reg || m_ready);
        use_slot0 = !phase_reg && ctl0.present;
        sel_ctl   = use_slot0 ? ctl0 : ctl1;
        sel_start = use_slot0 ? start0 : start1;
        sel_count = use_slot0 ? count0 : count1;

        // Retire the entry once its last pending result has been loaded.
        phase_next = phase_reg;
        q_pop      = 1'b0;
        if (load) begin
            if (use_slot0 && ctl1.present) begin
                phase_next = 1'b1;
            end else begin
                phase_next = 1'b0;
                q_pop      = 1'b1;
            end
        end

        sat_shift   = 6'd32 - {1'b0, block_shift};
        saturate    = ((sel_count >> sat_shift) != '0);
        offset_calc = OFFSET_BITS'(sel_start) << block_shift;
        bytes_wide  = OFFSET_BITS'(sel_count) << block_shift;
        bytes_calc  = saturate ? '1 : bytes_wide[BYTES_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ext_valid_reg <= sel_ctl.ext_valid;
            offset_reg    <= offset_calc;
            bytes_reg     <= bytes_calc;
            end_reg       <= sel_ctl.list_end;
        end
    end

    assign m_valid         = valid_reg;
    assign m_extent_valid  = ext_valid_reg;
    assign m_extent_offset = offset_reg;
    assign m_extent_bytes  = bytes_reg;
    assign m_list_end      = end_reg;

endmodule

>>> rtl/dirty_bitmap_extent_coalescer_top.sv
// Dirty-bitmap extent coalescer. The block takes a disk's dirty bitmap one
// bit per transfer, in block order, and returns copy extents as a byte offset
// and a byte length, scaled by block_shift. A run opens at a dirty block and is
// cut into an extent of exactly max_run_blocks blocks when a dirty block
// arrives that far from the run start. A clean block closes the run once it
// lies at least min_run_blocks from the run start; the extent then ends at the
// last dirty block, so shorter clean gaps are merged into the run. The
// transfer flagged final_block flushes any open run and sets list_end on the
// last result; when nothing is left to flush and that bitmap bit produced no
// extent, an end marker with extent_valid low and zero offset and length is
// returned instead. Lengths that do not fit in 32 bits saturate to all ones.
// Timing: one bitmap bit is accepted every clock cycle while the four-entry
// queue between the classifier and the formatter has room. Results leave at
// one per cycle from a registered output while m_ready is high, so a bit that
// produces two results presents them one after the other; the queue absorbs
// these bursts and any back-pressure on the result channel. A result passes
// through the queue and then the registered output stage before m_valid
// rises. Configuration is written through a plain write port, with no wait
// state, and must only be changed while the block is idle.
module dirty_bitmap_extent_coalescer_top #(
    parameter int BLOCK_INDEX_BITS = dbec_pkg::BLOCK_INDEX_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dbec_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dbec_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_block_dirty,
    input  logic                               s_final_block,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_extent_valid,
    output logic [dbec_pkg::OFFSET_BITS-1:0]   m_extent_offset,
    output logic [dbec_pkg::BYTES_BITS-1:0]    m_extent_bytes,
    output logic                               m_list_end
);
    import dbec_pkg::*;

    localparam int CTL_BITS  = $bits(res_ctl_t);
    localparam int SLOT_BITS = CTL_BITS + BLOCK_INDEX_BITS + BLOCK_INDEX_BITS + 1;
    localparam int ENTRY_BITS = 2 * SLOT_BITS;

    // Configuration registers.
    logic [15:0] min_run_reg;
    logic [15:0] max_run_reg;
    logic [4:0]  shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_run_reg <= MIN_RUN_BLOCKS_RESET;
            max_run_reg <= MAX_RUN_BLOCKS_RESET;
            shift_reg   <= BLOCK_SHIFT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MIN_RUN_BLOCKS: min_run_reg <= cfg_wdata;
                REG_MAX_RUN_BLOCKS: max_run_reg <= cfg_wdata;
                REG_BLOCK_SHIFT:    shift_reg   <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: run tracking and classification of each bitmap bit.
    res_ctl_t                    f_ctl0;
    res_ctl_t                    f_ctl1;
    logic [BLOCK_INDEX_BITS-1:0] f_start0;
    logic [BLOCK_INDEX_BITS-1:0] f_start1;
    logic [BLOCK_INDEX_BITS:0]   f_count0;
    logic [BLOCK_INDEX_BITS:0]   f_count1;
    logic                        s_accept;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_empty;
    logic                        q_full;
    logic [ENTRY_BITS-1:0]       q_in;
    logic [ENTRY_BITS-1:0]       q_head;

    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;

    dbec_front #(
        .IDX_BITS(BLOCK_INDEX_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (s_accept),
        .block_dirty    (s_block_dirty),
        .final_block    (s_final_block),
        .min_run_blocks (min_run_reg),
        .max_run_blocks (max_run_reg),
        .ctl0           (f_ctl0),
        .start0         (f_start0),
        .count0         (f_count0),
        .ctl1           (f_ctl1),
        .start1         (f_start1),
        .count1         (f_count1)
    );

    // Only bits that produce at least one result take a queue entry.
    assign q_push = s_accept && (f_ctl0.present || f_ctl1.present);
    assign q_in   = {f_ctl1, f_start1, f_count1, f_ctl0, f_start0, f_count0};

    dbec_queue #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back end: scaling to bytes and the registered result stage.
    res_ctl_t                    b_ctl0;
    res_ctl_t                    b_ctl1;
    logic [BLOCK_INDEX_BITS-1:0] b_start0;
    logic [BLOCK_INDEX_BITS-1:0] b_start1;
    logic [BLOCK_INDEX_BITS:0]   b_count0;
    logic [BLOCK_INDEX_BITS:0]   b_count1;

    assign {b_ctl1, b_start1, b_count1, b_ctl0, b_start0, b_count0} = q_head;

    dbec_back #(
        .IDX_BITS(BLOCK_INDEX_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .ctl0            (b_ctl0),
        .start0          (b_start0),
        .count0          (b_count0),
        .ctl1            (b_ctl1),
        .start1          (b_start1),
        .count1          (b_count1),
        .block_shift     (shift_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_extent_valid  (m_extent_valid),
        .m_extent_offset (m_extent_offset),
        .m_extent_bytes  (m_extent_bytes),
        .m_list_end      (m_list_end)
    );

endmodule
